[hdl/rsg_pkg.sv]
package rsg_pkg;

  localparam int IDX_W  = 22;
  localparam int STEP_W = 6;
  localparam int CRD_W  = 32;
  localparam int VEC_W  = 35;
  localparam int ROT_W  = 42;
  localparam int RAD_W  = 36;
  localparam int RR_W   = 40;
  localparam int ACC_W  = 38;
  localparam int AXV_W  = 39;
  localparam int ANG_W  = 32;
  localparam int RZ_W   = 33;
  localparam int SWP_W  = 17;
  localparam int CNT_W  = 17;
  localparam int PP_W   = 52;

  localparam int MAX_STEPS_DEF     = 63;
  localparam int MAX_POINTS_DEF    = 65536;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam logic [29:0] INV_GAIN = 30'd652032874;

  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic [2:0] {
    CFG_AXIS,
    CFG_STEPS,
    CFG_SWEEP,
    CFG_RDELTA,
    CFG_ASHIFT,
    CFG_COUNT
  } cfg_idx_e;

  typedef struct packed {
    logic [IDX_W-1:0]        idx;
    logic [STEP_W-1:0]       step;
    logic                    last;
    logic                    on_axis;
    logic signed [CRD_W-1:0] ox;
    logic signed [CRD_W-1:0] oy;
    logic signed [CRD_W-1:0] oz;
    logic signed [AXV_W-1:0] axv;
    logic signed [AXV_W-1:0] rinc;
    logic [ANG_W-1:0]        ang;
  } copy_t;

  typedef struct packed {
    logic [32:0] qs;
    logic [5:0]  rs;
    logic [31:0] qr;
    logic [5:0]  rr;
    logic [31:0] qa;
    logic [5:0]  ra;
  } quot_t;

  function automatic logic [ANG_W-1:0] atan_turn(input int k);
    case (k)
      0:  return 32'h20000000;
      1:  return 32'h12E4051E;
      2:  return 32'h09FB385B;
      3:  return 32'h051111D4;
      4:  return 32'h028B0D43;
      5:  return 32'h0145D7E1;
      6:  return 32'h00A2F61E;
      7:  return 32'h00517C55;
      8:  return 32'h0028BE53;
      9:  return 32'h00145F2F;
      10: return 32'h000A2F98;
      11: return 32'h000517CC;
      12: return 32'h00028BE6;
      13: return 32'h000145F3;
      14: return 32'h0000A2FA;
      15: return 32'h0000517D;
      16: return 32'h000028BE;
      17: return 32'h0000145F;
      18: return 32'h00000A30;
      19: return 32'h00000518;
      20: return 32'h0000028C;
      21: return 32'h00000146;
      22: return 32'h000000A3;
      23: return 32'h00000051;
      24: return 32'h00000029;
      25: return 32'h00000014;
      26: return 32'h0000000A;
      27: return 32'h00000005;
      28: return 32'h00000003;
      29: return 32'h00000001;
      30: return 32'h00000001;
      default: return 32'h00000000;
    endcase
  endfunction

  function automatic logic [CRD_W-1:0] sat42(input logic signed [ROT_W-1:0] v);
    if (v[ROT_W-1:CRD_W-1] == '0 || v[ROT_W-1:CRD_W-1] == '1) begin
      return v[CRD_W-1:0];
    end
    return v[ROT_W-1] ? 32'h80000000 : 32'h7FFFFFFF;
  endfunction

endpackage

[hdl/rsg_div.sv]
module rsg_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [5:0]    n_i,
  input  logic [32:0]   s_i,
  input  logic [31:0]   r_i,
  input  logic [31:0]   a_i,
  output logic          busy_o,
  output rsg_pkg::quot_t quot_o
);
  import rsg_pkg::*;

  logic        busy_q;
  logic [5:0]  cnt_q;
  logic [5:0]  rs_q, rr_q, ra_q;
  logic [32:0] qs_q;
  logic [31:0] qr_q, qa_q;
  logic [5:0]  bi;
  logic [32:0] ext_r, ext_a;
  logic [6:0]  st_s, st_r, st_a;

  function automatic logic [6:0] dstep(input logic [5:0] rem, input logic b,
                                       input logic [5:0] n);
    logic [6:0] t;
    t = {rem, b};
    if (t >= {1'b0, n}) begin
      return {1'b1, 6'(t - {1'b0, n})};
    end
    return {1'b0, t[5:0]};
  endfunction

  assign bi    = 6'd32 - cnt_q;
  assign ext_r = {1'b0, r_i};
  assign ext_a = {1'b0, a_i};
  assign st_s  = dstep(rs_q, s_i[bi], n_i);
  assign st_r  = dstep(rr_q, ext_r[bi], n_i);
  assign st_a  = dstep(ra_q, ext_a[bi], n_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
      rs_q   <= '0;
      rr_q   <= '0;
      ra_q   <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
      rs_q   <= '0;
      rr_q   <= '0;
      ra_q   <= '0;
    end else if (busy_q) begin
      rs_q  <= st_s[5:0];
      rr_q  <= st_r[5:0];
      ra_q  <= st_a[5:0];
      cnt_q <= cnt_q + 6'd1;
      if (cnt_q == 6'd32) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && !start_i) begin
      qs_q <= {qs_q[31:0], st_s[6]};
      qr_q <= {qr_q[30:0], st_r[6]};
      qa_q <= {qa_q[30:0], st_a[6]};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = '{qs: qs_q, rs: rs_q, qr: qr_q, rr: rr_q, qa: qa_q, ra: ra_q};

endmodule

[hdl/rsg_vec_cell.sv]
module rsg_vec_cell #(
  parameter int K = 0
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic signed [rsg_pkg::VEC_W-1:0] x_i,
  input  logic signed [rsg_pkg::VEC_W-1:0] y_i,
  input  logic [rsg_pkg::ANG_W-1:0]        z_i,
  input  rsg_pkg::copy_t                   pay_i,
  output logic                             valid_o,
  output logic signed [rsg_pkg::VEC_W-1:0] x_o,
  output logic signed [rsg_pkg::VEC_W-1:0] y_o,
  output logic [rsg_pkg::ANG_W-1:0]        z_o,
  output rsg_pkg::copy_t                   pay_o
);
  import rsg_pkg::*;

  logic signed [VEC_W-1:0] x_d, y_d;
  logic [ANG_W-1:0]        z_d;

  always_comb begin
    if (y_i[VEC_W-1]) begin
      x_d = x_i - (y_i >>> K);
      y_d = y_i + (x_i >>> K);
      z_d = z_i - atan_turn(K);
    end else begin
      x_d = x_i + (y_i >>> K);
      y_d = y_i - (x_i >>> K);
      z_d = z_i + atan_turn(K);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o   <= x_d;
      y_o   <= y_d;
      z_o   <= z_d;
      pay_o <= pay_i;
    end
  end

endmodule

[hdl/rsg_rot_cell.sv]
module rsg_rot_cell #(
  parameter int K = 0
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic signed [rsg_pkg::ROT_W-1:0] x_i,
  input  logic signed [rsg_pkg::ROT_W-1:0] y_i,
  input  logic signed [rsg_pkg::RZ_W-1:0]  z_i,
  input  rsg_pkg::copy_t                   pay_i,
  output logic                             valid_o,
  output logic signed [rsg_pkg::ROT_W-1:0] x_o,
  output logic signed [rsg_pkg::ROT_W-1:0] y_o,
  output logic signed [rsg_pkg::RZ_W-1:0]  z_o,
  output rsg_pkg::copy_t                   pay_o
);
  import rsg_pkg::*;

  logic signed [ROT_W-1:0] x_d, y_d;
  logic signed [RZ_W-1:0]  z_d;
  logic signed [RZ_W-1:0]  at;

  assign at = $signed({1'b0, atan_turn(K)});

  always_comb begin
    if (!z_i[RZ_W-1]) begin
      x_d = x_i - (y_i >>> K);
      y_d = y_i + (x_i >>> K);
      z_d = z_i - at;
    end else begin
      x_d = x_i + (y_i >>> K);
      y_d = y_i - (x_i >>> K);
      z_d = z_i + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o   <= x_d;
      y_o   <= y_d;
      z_o   <= z_d;
      pay_o <= pay_i;
    end
  end

endmodule

[hdl/rotational_sweep_point_generator_top.sv]
// Channel  Direction  Handshake              Payload
// cfg      in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
// in       in         in_valid_i/in_ready_o   in_point_index_i, in_x_i, in_y_i, in_z_i
// out      out        out_valid_o/out_ready_i out_index_o, out_step_o, out_x_o..out_z_o, out_last_o
//
// A point yields n_eff+1 copies (13 at reset), one per cycle from the level sequencer while not held.
// Path from issue: input register, vectoring chain, radius registers, rotation chain, output register.
// After reset and after every config transfer, a divider run holds in_ready_o low.
// The whole pipeline holds while the output register is full and out_ready_i is low.
module rotational_sweep_point_generator_top #(
  parameter int MAX_STEPS     = rsg_pkg::MAX_STEPS_DEF,
  parameter int MAX_POINTS    = rsg_pkg::MAX_POINTS_DEF,
  parameter int CORDIC_STAGES = rsg_pkg::CORDIC_STAGES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [2:0]                        cfg_index_i,
  input  logic [31:0]                       cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [15:0]                       in_point_index_i,
  input  logic signed [rsg_pkg::CRD_W-1:0]  in_x_i,
  input  logic signed [rsg_pkg::CRD_W-1:0]  in_y_i,
  input  logic signed [rsg_pkg::CRD_W-1:0]  in_z_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [rsg_pkg::IDX_W-1:0]         out_index_o,
  output logic [rsg_pkg::STEP_W-1:0]        out_step_o,
  output logic signed [rsg_pkg::CRD_W-1:0]  out_x_o,
  output logic signed [rsg_pkg::CRD_W-1:0]  out_y_o,
  output logic signed [rsg_pkg::CRD_W-1:0]  out_z_o,
  output logic                              out_last_o
);
  import rsg_pkg::*;

  localparam int CS = CORDIC_STAGES;
  localparam logic [STEP_W-1:0] MAXN = STEP_W'(MAX_STEPS);
  localparam logic [CNT_W-1:0]  MAXP = CNT_W'(MAX_POINTS);

  logic [1:0]              axis_q;
  logic [STEP_W-1:0]       steps_q;
  logic [SWP_W-1:0]        sweep_q;
  logic signed [31:0]      rdelta_q, ashift_q;
  logic [CNT_W-1:0]        pcount_q;

  logic [STEP_W-1:0]       n_eff;
  logic [CNT_W-1:0]        pc_eff;
  logic [31:0]             rmag, amag;
  logic                    div_busy;
  quot_t                   quot;

  logic                    adv, at_last, in_fire, issue;
  logic                    busy_q, busy_d;
  logic [STEP_W-1:0]       lvl_q;
  logic [IDX_W-1:0]        idx_q;
  logic [ANG_W-1:0]        rot_q;
  logic [5:0]              rotr_q, radr_q, axr_q;
  logic [ACC_W-1:0]        radq_q, axq_q;
  logic signed [CRD_W-1:0] pt_x_q, pt_y_q, pt_z_q;

  logic [6:0]              t_s, t_r, t_a;
  logic                    c_s, c_r, c_a;

  logic signed [CRD_W-1:0] sa, sb, sax;
  logic signed [VEC_W-1:0] fa, fb, x0, y0;
  logic [ANG_W-1:0]        z0;
  logic signed [AXV_W-1:0] ainc, rinc;
  copy_t                   p0;

  logic [CS:0]             vv;
  logic signed [VEC_W-1:0] vx [CS+1];
  logic signed [VEC_W-1:0] vy [CS+1];
  logic [ANG_W-1:0]        vz [CS+1];
  copy_t                   vp [CS+1];

  logic signed [VEC_W+30:0] gp;
  logic                    v1_q, v2_q, v3_q, v4_q;
  logic signed [RAD_W-1:0] rad1_q;
  copy_t                   p1_d;
  copy_t                   p1_q, p2_q, p3_q, p4_q;
  logic signed [RR_W-1:0]  r2_q;
  logic signed [PP_W-1:0]  plo3_q, phi3_q;
  logic signed [71:0]      sum4;
  logic signed [ROT_W-1:0] rr4_q, x5;
  logic [ANG_W-1:0]        ang5;
  logic                    fl5;
  logic signed [RZ_W-1:0]  z5;

  logic [CS:0]             rv;
  logic signed [ROT_W-1:0] rx [CS+1];
  logic signed [ROT_W-1:0] ry [CS+1];
  logic signed [RZ_W-1:0]  rz [CS+1];
  copy_t                   rp [CS+1];

  logic signed [CRD_W-1:0] ra, rb, rax, ox_d, oy_d, oz_d;
  logic                    out_valid_q;

  // config
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q   <= AXIS_Z;
      steps_q  <= 6'd12;
      sweep_q  <= 17'd65536;
      rdelta_q <= '0;
      ashift_q <= '0;
      pcount_q <= 17'd1;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_AXIS:   axis_q   <= cfg_data_i[1:0];
        CFG_STEPS:  steps_q  <= cfg_data_i[STEP_W-1:0];
        CFG_SWEEP:  sweep_q  <= cfg_data_i[SWP_W-1:0];
        CFG_RDELTA: rdelta_q <= $signed(cfg_data_i);
        CFG_ASHIFT: ashift_q <= $signed(cfg_data_i);
        CFG_COUNT:  pcount_q <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (steps_q == '0) begin
      n_eff = STEP_W'(1);
    end else if (steps_q > MAXN) begin
      n_eff = MAXN;
    end else begin
      n_eff = steps_q;
    end
    if (25'(pcount_q) > 25'(MAX_POINTS)) begin
      pc_eff = MAXP;
    end else begin
      pc_eff = pcount_q;
    end
  end

  assign rmag = rdelta_q[31] ? 32'(~rdelta_q + 32'sd1) : 32'(rdelta_q);
  assign amag = ashift_q[31] ? 32'(~ashift_q + 32'sd1) : 32'(ashift_q);

  rsg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cfg_valid_i),
    .n_i     (n_eff),
    .s_i     ({sweep_q, 16'd0}),
    .r_i     (rmag),
    .a_i     (amag),
    .busy_o  (div_busy),
    .quot_o  (quot)
  );

  // level sequencer
  assign adv        = !out_valid_q || out_ready_i;
  assign at_last    = lvl_q == n_eff;
  assign in_ready_o = adv && !div_busy && (!busy_q || at_last);
  assign in_fire    = in_valid_i && in_ready_o;
  assign issue      = adv && busy_q;

  assign t_s = {1'b0, rotr_q} + {1'b0, quot.rs};
  assign t_r = {1'b0, radr_q} + {1'b0, quot.rr};
  assign t_a = {1'b0, axr_q} + {1'b0, quot.ra};
  assign c_s = t_s >= {1'b0, n_eff};
  assign c_r = t_r >= {1'b0, n_eff};
  assign c_a = t_a >= {1'b0, n_eff};

  always_comb begin
    busy_d = busy_q;
    if (in_fire) begin
      busy_d = 1'b1;
    end else if (issue && at_last) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      lvl_q  <= '0;
    end else begin
      busy_q <= busy_d;
      if (in_fire) begin
        lvl_q <= '0;
      end else if (issue && !at_last) begin
        lvl_q <= lvl_q + 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pt_x_q <= in_x_i;
      pt_y_q <= in_y_i;
      pt_z_q <= in_z_i;
      idx_q  <= IDX_W'(in_point_index_i);
      rot_q  <= '0;
      rotr_q <= '0;
      radq_q <= '0;
      radr_q <= '0;
      axq_q  <= '0;
      axr_q  <= '0;
    end else if (issue && !at_last) begin
      idx_q  <= idx_q + IDX_W'(pc_eff);
      rot_q  <= rot_q + quot.qs[31:0] + {31'd0, c_s};
      rotr_q <= c_s ? 6'(t_s - {1'b0, n_eff}) : t_s[5:0];
      radq_q <= radq_q + ACC_W'(quot.qr) + {37'd0, c_r};
      radr_q <= c_r ? 6'(t_r - {1'b0, n_eff}) : t_r[5:0];
      axq_q  <= axq_q + ACC_W'(quot.qa) + {37'd0, c_a};
      axr_q  <= c_a ? 6'(t_a - {1'b0, n_eff}) : t_a[5:0];
    end
  end

  // plane select and half-plane fold
  always_comb begin
    case (axis_q)
      AXIS_Z: begin
        sa = pt_x_q; sb = pt_y_q; sax = pt_z_q;
      end
      AXIS_Y: begin
        sa = pt_x_q; sb = pt_z_q; sax = pt_y_q;
      end
      default: begin
        sa = pt_y_q; sb = pt_z_q; sax = pt_x_q;
      end
    endcase
    fa   = $signed({{3{sa[31]}}, sa});
    fb   = $signed({{3{sb[31]}}, sb});
    x0   = sa[31] ? -fa : fa;
    y0   = sa[31] ? -fb : fb;
    z0   = sa[31] ? 32'h80000000 : 32'h00000000;
    ainc = ashift_q[31] ? -$signed({1'b0, axq_q}) : $signed({1'b0, axq_q});
    rinc = rdelta_q[31] ? -$signed({1'b0, radq_q}) : $signed({1'b0, radq_q});
    p0.idx     = idx_q;
    p0.step    = lvl_q;
    p0.last    = at_last;
    p0.on_axis = (sa == '0) && (sb == '0);
    p0.ox      = pt_x_q;
    p0.oy      = pt_y_q;
    p0.oz      = pt_z_q;
    p0.axv     = $signed({{7{sax[31]}}, sax}) + ainc;
    p0.rinc    = rinc;
    p0.ang     = rot_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vv[0] <= 1'b0;
    end else if (adv) begin
      vv[0] <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vx[0] <= x0;
      vy[0] <= y0;
      vz[0] <= z0;
      vp[0] <= p0;
    end
  end

  for (genvar k = 0; k < CS; k++) begin : g_vec
    rsg_vec_cell #(.K(k)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (vv[k]),
      .x_i     (vx[k]),
      .y_i     (vy[k]),
      .z_i     (vz[k]),
      .pay_i   (vp[k]),
      .valid_o (vv[k+1]),
      .x_o     (vx[k+1]),
      .y_o     (vy[k+1]),
      .z_o     (vz[k+1]),
      .pay_o   (vp[k+1])
    );
  end

  // radius: remove gain, grow, remove gain again
  assign gp   = vx[CS] * $signed({1'b0, INV_GAIN});
  assign sum4 = ($signed({{20{phi3_q[PP_W-1]}}, phi3_q}) <<< 20)
              + $signed({{20{plo3_q[PP_W-1]}}, plo3_q}) + 72'sd536870912;

  always_comb begin
    p1_d     = vp[CS];
    p1_d.ang = vz[CS] + vp[CS].ang;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= vv[CS];
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rad1_q   <= RAD_W'((gp + (VEC_W+31)'(536870912)) >>> 30);
      p1_q     <= p1_d;
      r2_q     <= $signed({{4{rad1_q[RAD_W-1]}}, rad1_q})
                + $signed({p1_q.rinc[AXV_W-1], p1_q.rinc});
      p2_q     <= p1_q;
      plo3_q   <= $signed({1'b0, r2_q[19:0]}) * $signed({1'b0, INV_GAIN});
      phi3_q   <= PP_W'($signed(r2_q[RR_W-1:20]) * $signed({1'b0, INV_GAIN}));
      p3_q     <= p2_q;
      rr4_q    <= sum4[71:30];
      p4_q     <= p3_q;
    end
  end

  // quarter fold ahead of the rotation chain
  assign fl5  = ang5[31];
  assign ang5 = p4_q.ang + 32'h40000000;
  assign x5   = fl5 ? -rr4_q : rr4_q;
  assign z5   = fl5 ? $signed({~p4_q.ang[31], ~p4_q.ang[31], p4_q.ang[30:0]})
                    : $signed({p4_q.ang[31], p4_q.ang});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv[0] <= 1'b0;
    end else if (adv) begin
      rv[0] <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rx[0] <= x5;
      ry[0] <= '0;
      rz[0] <= z5;
      rp[0] <= p4_q;
    end
  end

  for (genvar k = 0; k < CS; k++) begin : g_rot
    rsg_rot_cell #(.K(k)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (rv[k]),
      .x_i     (rx[k]),
      .y_i     (ry[k]),
      .z_i     (rz[k]),
      .pay_i   (rp[k]),
      .valid_o (rv[k+1]),
      .x_o     (rx[k+1]),
      .y_o     (ry[k+1]),
      .z_o     (rz[k+1]),
      .pay_o   (rp[k+1])
    );
  end

  // saturate and place coordinates; step 0 passes the input point through
  always_comb begin
    ra  = rp[CS].on_axis ? '0 : $signed(sat42(rx[CS]));
    rb  = rp[CS].on_axis ? '0 : $signed(sat42(ry[CS]));
    rax = $signed(sat42($signed({{3{rp[CS].axv[AXV_W-1]}}, rp[CS].axv})));
    case (axis_q)
      AXIS_Z: begin
        ox_d = ra; oy_d = rb; oz_d = rax;
      end
      AXIS_Y: begin
        ox_d = ra; oy_d = rax; oz_d = rb;
      end
      default: begin
        ox_d = rax; oy_d = ra; oz_d = rb;
      end
    endcase
    if (rp[CS].step == '0) begin
      ox_d = rp[CS].ox;
      oy_d = rp[CS].oy;
      oz_d = rp[CS].oz;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= rv[CS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_index_o <= rp[CS].idx;
      out_step_o  <= rp[CS].step;
      out_last_o  <= rp[CS].last;
      out_x_o     <= ox_d;
      out_y_o     <= oy_d;
      out_z_o     <= oz_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[tb/rotational_sweep_point_generator_top_test.sv]
`timescale 1ns / 100ps

module rotational_sweep_point_generator_top_test;
  import rsg_pkg::*;

  typedef struct {
    logic [IDX_W-1:0]  idx;
    logic [STEP_W-1:0] step;
    logic [31:0]       x;
    logic [31:0]       y;
    logic [31:0]       z;
    logic              last;
  } sweep_copy_t;

  class sweep_scoreboard;
    logic [1:0]   axis;
    logic [5:0]   nsteps;
    logic [16:0]  sweep;
    longint       rdelta;
    longint       ashift;
    logic [16:0]  pcount;
    sweep_copy_t  pending[$];
    int           errors;
    int           checked;

    function new();
      axis = 2;
      nsteps = 12;
      sweep = 65536;
      rdelta = 0;
      ashift = 0;
      pcount = 1;
      errors = 0;
      checked = 0;
    endfunction

    function void write_reg(cfg_idx_e r, logic [31:0] d);
      case (r)
        CFG_AXIS:   axis = d[1:0];
        CFG_STEPS:  nsteps = d[5:0];
        CFG_SWEEP:  sweep = d[16:0];
        CFG_RDELTA: rdelta = longint'($signed(d));
        CFG_ASHIFT: ashift = longint'($signed(d));
        CFG_COUNT:  pcount = d[16:0];
        default: ;
      endcase
    endfunction

    function longint shr(longint v, int k);
      return v >>> k;
    endfunction

    function longint atan_k(int k);
      return longint'(atan_turn(k));
    endfunction

    function longint remove_gain(longint v);
      return shr(v * 64'sd652032874 + (64'sd1 <<< 29), 30);
    endfunction

    function logic [31:0] clip(longint v);
      if (v > 64'sd2147483647) return 32'h7FFFFFFF;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[31:0];
    endfunction

    function void note_point(logic [15:0] pidx, logic [31:0] ix, logic [31:0] iy,
                             logic [31:0] iz);
      longint c[3];
      longint pa, pb, ax, n, pc, a, b, t, ang, rad, r, ra, rb, zz;
      longint v[3];
      logic [31:0] theta, phi;
      longint unsigned rot;
      int ia, ib, iax;
      bit on_axis;
      sweep_copy_t e;
      c[0] = longint'($signed(ix));
      c[1] = longint'($signed(iy));
      c[2] = longint'($signed(iz));
      if (axis == 2) begin ia = 0; ib = 1; iax = 2; end
      else if (axis == 1) begin ia = 0; ib = 2; iax = 1; end
      else begin ia = 1; ib = 2; iax = 0; end
      pa = c[ia];
      pb = c[ib];
      ax = c[iax];
      n = (nsteps == 0) ? 1 : nsteps;
      pc = (pcount > 65536) ? 65536 : pcount;
      on_axis = (pa == 0 && pb == 0);
      rad = 0;
      theta = 0;
      if (!on_axis) begin
        a = pa; b = pb; ang = 0;
        if (a < 0) begin a = -a; b = -b; ang = 64'h80000000; end
        for (int k = 0; k < CORDIC_STAGES_DEF; k++) begin
          if (b < 0) begin
            t = a - shr(b, k); b = b + shr(a, k); ang -= atan_k(k);
          end else begin
            t = a + shr(b, k); b = b - shr(a, k); ang += atan_k(k);
          end
          a = t;
        end
        theta = ang[31:0];
        rad = remove_gain(a);
      end
      for (int i = 0; i <= n; i++) begin
        e.idx = IDX_W'(64'(pidx) + 64'(i) * 64'(pc));
        e.step = STEP_W'(i);
        e.last = (i == n);
        if (i == 0) begin
          v = c;
        end else begin
          ra = 0; rb = 0;
          if (!on_axis) begin
            rot = (64'(i) * 64'(sweep) * 64'd65536) / 64'(n);
            phi = theta + rot[31:0];
            r = remove_gain(rad + (i * rdelta) / n);
            a = r; b = 0;
            if (((phi + 32'h40000000) & 32'h80000000) != 0) begin
              a = -a; phi = phi ^ 32'h80000000;
            end
            zz = longint'($signed(phi));
            for (int k = 0; k < CORDIC_STAGES_DEF; k++) begin
              if (zz >= 0) begin
                t = a - shr(b, k); b = b + shr(a, k); zz -= atan_k(k);
              end else begin
                t = a + shr(b, k); b = b - shr(a, k); zz += atan_k(k);
              end
              a = t;
            end
            ra = a; rb = b;
          end
          v[ia] = ra;
          v[ib] = rb;
          v[iax] = ax + (i * ashift) / n;
        end
        e.x = clip(v[0]);
        e.y = clip(v[1]);
        e.z = clip(v[2]);
        pending.push_back(e);
      end
    endfunction

    function void check_copy(logic [IDX_W-1:0] idx, logic [STEP_W-1:0] step,
                             logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic last);
      sweep_copy_t e;
      checked++;
      if (pending.size() == 0) begin
        $error("unexpected output copy idx=%0d step=%0d", idx, step);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (idx !== e.idx) begin
        $error("out_index: expected %0d actual %0d", e.idx, idx); errors++;
      end
      if (step !== e.step) begin
        $error("out_step: expected %0d actual %0d", e.step, step); errors++;
      end
      if (x !== e.x) begin
        $error("out_x: expected %h actual %h", e.x, x); errors++;
      end
      if (y !== e.y) begin
        $error("out_y: expected %h actual %h", e.y, y); errors++;
      end
      if (z !== e.z) begin
        $error("out_z: expected %h actual %h", e.z, z); errors++;
      end
      if (last !== e.last) begin
        $error("out_last: expected %0d actual %0d", e.last, last); errors++;
      end
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [2:0]               cfg_index_i = '0;
  logic [31:0]              cfg_data_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [15:0]              in_point_index_i = '0;
  logic signed [CRD_W-1:0]  in_x_i = '0;
  logic signed [CRD_W-1:0]  in_y_i = '0;
  logic signed [CRD_W-1:0]  in_z_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic [IDX_W-1:0]         out_index_o;
  logic [STEP_W-1:0]        out_step_o;
  logic signed [CRD_W-1:0]  out_x_o;
  logic signed [CRD_W-1:0]  out_y_o;
  logic signed [CRD_W-1:0]  out_z_o;
  logic                     out_last_o;

  rotational_sweep_point_generator_top dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  sweep_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_cycles = 0;
  int points_sent = 0;

  task automatic write_reg(cfg_idx_e r, logic [31:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(r, d);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_point(logic [15:0] p, logic [31:0] x, logic [31:0] y,
                            logic [31:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_point_index_i <= p;
    in_x_i <= x;
    in_y_i <= y;
    in_z_i <= z;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_point(p, x, y, z);
    points_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (2 * CORDIC_STAGES_DEF + 12) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 0;
      3: return $urandom_range(2000000) - 1000000;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_points(int cnt);
    for (int k = 0; k < cnt; k++)
      send_point($urandom, rand_coord(), rand_coord(), rand_coord());
  endtask

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i)
      sb.check_copy(out_index_o, out_step_o, out_x_o, out_y_o, out_z_o, out_last_o);
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: default settings, extremes and on-axis point
    send_point(16'h0000, 32'h00010000, 32'h0, 32'h0);
    send_point(16'hFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_point(16'h1234, 32'h80000000, 32'h80000000, 32'h80000000);
    send_point(16'h0005, 32'h0, 32'h0, 32'h00050000);
    send_point(16'h0006, 32'hFFFF0000, 32'h00030000, 32'hFFFFFFFF);
    drain();

    write_reg(CFG_AXIS, 0);
    write_reg(CFG_STEPS, 0);
    write_reg(CFG_SWEEP, 17'h1FFFF);
    write_reg(CFG_RDELTA, 32'h80000000);
    write_reg(CFG_ASHIFT, 32'h7FFFFFFF);
    write_reg(CFG_COUNT, 0);
    send_point(16'h00AA, 32'h00020000, 32'h0, 32'h0);
    send_point(16'hFFFF, 32'h00010000, 32'h00040000, 32'hFFFD0000);
    drain();

    write_reg(CFG_AXIS, 3);
    write_reg(CFG_STEPS, 63);
    write_reg(CFG_SWEEP, 0);
    write_reg(CFG_RDELTA, 32'hFFF00000);
    write_reg(CFG_ASHIFT, 32'h80000000);
    write_reg(CFG_COUNT, 17'h1FFFF);
    send_point(16'hFFFF, 32'h00010000, 32'h00010000, 32'h00010000);
    send_point(16'h0001, 32'h0, 32'h0, 32'h0);
    drain();

    write_reg(CFG_AXIS, 1);
    write_reg(CFG_STEPS, 7);
    write_reg(CFG_SWEEP, 65536);
    write_reg(CFG_RDELTA, 32'h7FFFFFFF);
    write_reg(CFG_ASHIFT, 32'h00100000);
    write_reg(CFG_COUNT, 65536);
    send_point(16'h0010, 32'h00030000, 32'h12345678, 32'hFFFC0000);
    send_point(16'h0011, 32'hC0000000, 32'h0, 32'h3FFFFFFF);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        3: begin send_idle_pct = 28; recv_stall_pct = 28; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      write_reg(CFG_AXIS, $urandom_range(3));
      write_reg(CFG_STEPS, (ph == 0) ? 63 : $urandom_range(16));
      write_reg(CFG_SWEEP, $urandom);
      write_reg(CFG_RDELTA, rand_coord());
      write_reg(CFG_ASHIFT, rand_coord());
      write_reg(CFG_COUNT, $urandom);
      if (ph == 4) hold_off_cycles <= 400;
      random_points(ph == 0 ? 20 : 60);
      drain();
    end

    $display("covered %0d points, %0d output copies, all axes and register extremes",
             points_sent, sb.checked);
    if (sb.errors == 0)
      $display("rotational_sweep_point_generator_top regression: pass");
    else
      $display("rotational_sweep_point_generator_top regression: fail");
    $finish;
  end

  initial begin
    #8000000;
    $display("rotational_sweep_point_generator_top regression: fail");
    $finish;
  end

endmodule
